// ===== src/mcfd_pkg.sv =====
// shared types and constants for the cross filter mipmap downsampler
// no dependencies; imported by every module of the block
package mcfd_pkg;

  // default line store limits
  localparam int DEFAULT_MAX_WIDTH  = 2048;
  localparam int DEFAULT_MAX_HEIGHT = 2048;

  // configuration port
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 12;
  localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_HEIGHT = 1'b1;

  // payload widths
  localparam int PIX_W   = 32;
  localparam int COORD_W = 10;

  // queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QLW    = $clog2(QDEPTH + 1);

  // channel sums of up to five bytes, divided by a reciprocal multiply
  localparam int SUM_W       = 11;
  localparam int RECIP_W     = 12;
  localparam int RECIP_SHIFT = 13;
  localparam logic [RECIP_W-1:0] RECIP_3 = 12'd2731;
  localparam logic [RECIP_W-1:0] RECIP_4 = 12'd2048;
  localparam logic [RECIP_W-1:0] RECIP_5 = 12'd1639;

  // one output pixel's neighborhood, ready for averaging
  typedef struct packed {
    logic [PIX_W-1:0]   center;
    logic [PIX_W-1:0]   right;
    logic [PIX_W-1:0]   left;
    logic [PIX_W-1:0]   below;
    logic [PIX_W-1:0]   above;
    logic               has_left;
    logic               has_above;
    logic [COORD_W-1:0] ox;
    logic [COORD_W-1:0] oy;
    logic               last;
  } entry_t;

  // reciprocal of the neighbor count (3, 4 or 5)
  function automatic logic [RECIP_W-1:0] recip_sel(input logic has_left,
                                                   input logic has_above);
    logic [RECIP_W-1:0] r;
    if (has_left && has_above) r = RECIP_5;
    else if (has_left || has_above) r = RECIP_4;
    else r = RECIP_3;
    return r;
  endfunction

endpackage

// ===== src/mcfd_front.sv =====
// front end: size registers, raster counters, line stores, classification
// depends on mcfd_pkg; pushes one entry per output pixel into mcfd_queue
module mcfd_front #(
  parameter int MAX_WIDTH  = mcfd_pkg::DEFAULT_MAX_WIDTH,
  parameter int MAX_HEIGHT = mcfd_pkg::DEFAULT_MAX_HEIGHT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [mcfd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mcfd_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             push,
  output logic                             full,
  input  logic [mcfd_pkg::PIX_W-1:0]       pixel_color,
  input  logic                             q_almost_full,
  output logic                             q_push,
  output mcfd_pkg::entry_t                 q_entry
);
  import mcfd_pkg::*;

  localparam int XW     = $clog2(MAX_WIDTH);
  localparam int YW     = $clog2(MAX_HEIGHT);
  localparam int WW     = $clog2(MAX_WIDTH + 1);
  localparam int HW     = $clog2(MAX_HEIGHT + 1);
  localparam int PAW    = XW - 1;
  localparam int PDEPTH = (MAX_WIDTH + 1) / 2;
  localparam int CWW    = (WW > CFG_DATA_W) ? WW : CFG_DATA_W;
  localparam int CHW    = (HW > CFG_DATA_W) ? HW : CFG_DATA_W;

  logic [WW-1:0] width_eff, width_next;
  logic [HW-1:0] height_eff, height_next;
  logic [XW-1:0] col, col_next;
  logic [YW-1:0] row, row_next;
  logic          accept;
  logic          emit;
  logic [PAW-1:0] pair_addr;
  logic [XW-2:0] jx;
  logic [YW-2:0] iy;
  logic [CWW-1:0] wval;
  logic [CHW-1:0] hval;

  // line stores: even rows as column pairs, odd rows at even columns only
  logic [2*PIX_W-1:0] centre_mem [PDEPTH];
  logic [PIX_W-1:0]   above_mem  [PDEPTH];
  logic [2*PIX_W-1:0] centre_rd;
  logic [PIX_W-1:0]   above_rd;
  logic [PIX_W-1:0]   even_hold;
  logic [PIX_W-1:0]   left_hold;

  // first stage registers
  logic               s1_valid;
  logic [PIX_W-1:0]   s1_below;
  logic               s1_has_left;
  logic               s1_has_above;
  logic [COORD_W-1:0] s1_x;
  logic [COORD_W-1:0] s1_y;
  logic               s1_last;

  assign full      = q_almost_full;
  assign accept    = push && !full;
  assign jx        = col[XW-1:1];
  assign iy        = row[YW-1:1];
  assign pair_addr = col[XW-1:1];

  // output pixel sits on odd row, even column, inside the even-floored size
  assign emit = row[0] && !col[0] &&
                ((WW-1)'(jx) < width_eff[WW-1:1]) &&
                ((HW-1)'(iy) < height_eff[HW-1:1]);

  // size clamping on register write
  always_comb begin
    wval = CWW'(cfg_data);
    hval = CHW'(cfg_data);
    width_next  = width_eff;
    height_next = height_eff;
    if (cfg_write && cfg_index == REG_SOURCE_WIDTH) begin
      if (wval < CWW'(2)) width_next = WW'(2);
      else if (wval > CWW'(MAX_WIDTH)) width_next = WW'(MAX_WIDTH);
      else width_next = WW'(wval);
    end
    if (cfg_write && cfg_index == REG_SOURCE_HEIGHT) begin
      if (hval < CHW'(2)) height_next = HW'(2);
      else if (hval > CHW'(MAX_HEIGHT)) height_next = HW'(MAX_HEIGHT);
      else height_next = HW'(hval);
    end
  end

  // raster counters, restarted by any register write
  always_comb begin
    col_next = col;
    row_next = row;
    if (cfg_write) begin
      col_next = '0;
      row_next = '0;
    end else if (accept) begin
      if (WW'(col) + WW'(1) >= width_eff) begin
        col_next = '0;
        if (HW'(row) + HW'(1) >= height_eff) row_next = '0;
        else row_next = row + YW'(1);
      end else begin
        col_next = col + XW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_eff  <= WW'(2);
      height_eff <= HW'(2);
      col        <= '0;
      row        <= '0;
    end else begin
      width_eff  <= width_next;
      height_eff <= height_next;
      col        <= col_next;
      row        <= row_next;
    end
  end

  // even row: pair up columns before writing
  always_ff @(posedge clk) begin
    if (accept && !row[0] && !col[0]) even_hold <= pixel_color;
  end

  always_ff @(posedge clk) begin
    if (accept && !row[0] && col[0]) centre_mem[pair_addr] <= {pixel_color, even_hold};
    if (accept && emit) centre_rd <= centre_mem[pair_addr];
  end

  // odd row store, read before the same entry is overwritten
  always_ff @(posedge clk) begin
    if (accept && emit) above_rd <= above_mem[pair_addr];
    if (accept && row[0] && !col[0]) above_mem[pair_addr] <= pixel_color;
  end

  // first stage: capture the classified item while the stores are read
  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else s1_valid <= accept && emit;
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      s1_below     <= pixel_color;
      s1_has_left  <= (jx != '0);
      s1_has_above <= (iy != '0);
      s1_x         <= COORD_W'(jx);
      s1_y         <= COORD_W'(iy);
      s1_last      <= ((WW-1)'(jx) == width_eff[WW-1:1] - (WW-1)'(1)) &&
                      ((HW-1)'(iy) == height_eff[HW-1:1] - (HW-1)'(1));
    end
  end

  // right pixel of this pair is the left neighbor of the next output
  always_ff @(posedge clk) begin
    if (s1_valid) left_hold <= centre_rd[2*PIX_W-1:PIX_W];
  end

  // queue entry
  assign q_push = s1_valid;
  always_comb begin
    q_entry.center    = centre_rd[PIX_W-1:0];
    q_entry.right     = centre_rd[2*PIX_W-1:PIX_W];
    q_entry.left      = left_hold;
    q_entry.below     = s1_below;
    q_entry.above     = above_rd;
    q_entry.has_left  = s1_has_left;
    q_entry.has_above = s1_has_above;
    q_entry.ox        = s1_x;
    q_entry.oy        = s1_y;
    q_entry.last      = s1_last;
  end

  // checks
  a_s1_from_accept: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> $past(accept && emit))
    else $error("front stage loaded without an output transfer");

  a_counters_in_range: assert property (@(posedge clk) disable iff (rst)
    (WW'(col) < width_eff) && (HW'(row) < height_eff))
    else $error("raster counter beyond source size");

endmodule

// ===== src/mcfd_queue.sv =====
// short register queue that decouples the front end from the averaging back end
// depends on mcfd_pkg for the entry type and depth
module mcfd_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  mcfd_pkg::entry_t wr_data,
  output logic             almost_full,
  input  logic             rd,
  output logic             q_empty,
  output mcfd_pkg::entry_t rd_data
);
  import mcfd_pkg::*;

  entry_t           slots [QDEPTH];
  logic [QAW-1:0]   wr_ptr;
  logic [QAW-1:0]   rd_ptr;
  logic [QLW-1:0]   level;

  // one slot is kept spare for the item still in the front stage
  assign almost_full = level >= QLW'(QDEPTH - 1);
  assign q_empty     = (level == '0);
  assign rd_data     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) slots[wr_ptr] <= wr_data;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (wr) wr_ptr <= wr_ptr + QAW'(1);
      if (rd) rd_ptr <= rd_ptr + QAW'(1);
      if (wr && !rd) level <= level + QLW'(1);
      else if (rd && !wr) level <= level - QLW'(1);
    end
  end

  // checks
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    wr |-> (level != QLW'(QDEPTH)) || rd)
    else $error("queue write while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    rd |-> level != '0)
    else $error("queue read while empty");

endmodule

// ===== src/mcfd_back.sv =====
// back end: per-channel sums, division by the neighbor count, output register
// depends on mcfd_pkg; reads entries from mcfd_queue
module mcfd_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_empty,
  output logic                         q_pop,
  input  mcfd_pkg::entry_t             q_data,
  output logic                         empty,
  input  logic                         pop,
  output logic [mcfd_pkg::PIX_W-1:0]   out_color,
  output logic [mcfd_pkg::COORD_W-1:0] out_x,
  output logic [mcfd_pkg::COORD_W-1:0] out_y,
  output logic                         last_pixel
);
  import mcfd_pkg::*;

  logic                     sum_ready;
  logic                     res_ready;
  logic [SUM_W-1:0]         sum_next [4];
  logic [SUM_W-1:0]         sum_q    [4];
  logic [RECIP_W-1:0]       recip_q;
  logic [COORD_W-1:0]       sx;
  logic [COORD_W-1:0]       sy;
  logic                     slast;
  logic                     sum_valid;
  logic [SUM_W+RECIP_W-1:0] prod [4];
  logic [PIX_W-1:0]         color_next;
  logic                     res_valid;

  assign res_ready = !res_valid || pop;
  assign sum_ready = !sum_valid || res_ready;
  assign q_pop     = !q_empty && sum_ready;
  assign empty     = !res_valid;

  // channel sums over the cross, absent neighbors masked
  always_comb begin
    for (int ch = 0; ch < 4; ch++) begin
      sum_next[ch] = SUM_W'(q_data.center[8*ch +: 8]) +
                     SUM_W'(q_data.right[8*ch +: 8]) +
                     SUM_W'(q_data.below[8*ch +: 8]) +
                     (q_data.has_left  ? SUM_W'(q_data.left[8*ch +: 8])  : '0) +
                     (q_data.has_above ? SUM_W'(q_data.above[8*ch +: 8]) : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) sum_valid <= 1'b0;
    else if (sum_ready) sum_valid <= q_pop;
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      for (int ch = 0; ch < 4; ch++) sum_q[ch] <= sum_next[ch];
      recip_q <= recip_sel(q_data.has_left, q_data.has_above);
      sx      <= q_data.ox;
      sy      <= q_data.oy;
      slast   <= q_data.last;
    end
  end

  // truncating divide by 3, 4 or 5 as a reciprocal multiply
  always_comb begin
    for (int ch = 0; ch < 4; ch++) begin
      prod[ch] = (SUM_W+RECIP_W)'(sum_q[ch]) * (SUM_W+RECIP_W)'(recip_q);
      color_next[8*ch +: 8] = prod[ch][RECIP_SHIFT +: 8];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) res_valid <= 1'b0;
    else if (res_ready) res_valid <= sum_valid;
  end

  always_ff @(posedge clk) begin
    if (res_ready && sum_valid) begin
      out_color  <= color_next;
      out_x      <= sx;
      out_y      <= sy;
      last_pixel <= slast;
    end
  end

  // checks
  a_sum_holds: assert property (@(posedge clk) disable iff (rst)
    sum_valid && !res_ready |=> sum_valid && $stable(recip_q) && $stable(sx))
    else $error("sum stage lost its item under stall");

endmodule

// ===== src/mipmap_cross_filter_downsampler.sv =====
// top level of the cross filter mipmap downsampler
// depends on mcfd_pkg, mcfd_front, mcfd_queue and mcfd_back
//
// Source pixels enter in raster order on the push/full channel, one per
// transfer. Output pixels of the next mipmap level leave on the empty/pop
// channel with their column, row and a flag on the level's final pixel.
// Each output is the per-channel mean of its source pixel at (2j,2i) and
// the cross neighbors inside the image, truncated.
// An output is produced by the transfer of the source pixel just below its
// center; empty falls after front stage, queue, sum and output registers.
// Throughput is one source pixel per cycle while full is low, set by the
// line stores, each written and read at most once per cycle, and the
// one-entry-per-cycle queue between front and back.
// Writing either size register restarts the frame at the top left corner;
// write only while no output is pending.
// Reset clears the counters and the pipeline and sets both sizes to 2; the
// line stores are not cleared and need no clearing pass.
// When the receiver stalls, results collect in a four-entry queue and full
// rises when one slot is left for the front stage item; no pixel is lost.
module mipmap_cross_filter_downsampler #(
  parameter int MAX_WIDTH  = mcfd_pkg::DEFAULT_MAX_WIDTH,
  parameter int MAX_HEIGHT = mcfd_pkg::DEFAULT_MAX_HEIGHT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [mcfd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mcfd_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             push,
  output logic                             full,
  input  logic [mcfd_pkg::PIX_W-1:0]       pixel_color,
  output logic                             empty,
  input  logic                             pop,
  output logic [mcfd_pkg::PIX_W-1:0]       out_color,
  output logic [mcfd_pkg::COORD_W-1:0]     out_x,
  output logic [mcfd_pkg::COORD_W-1:0]     out_y,
  output logic                             last_pixel
);
  import mcfd_pkg::*;

  logic   q_push;
  logic   q_almost_full;
  logic   q_pop;
  logic   q_empty;
  entry_t q_wr_entry;
  entry_t q_rd_entry;

  // classification and line stores
  mcfd_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .push         (push),
    .full         (full),
    .pixel_color  (pixel_color),
    .q_almost_full(q_almost_full),
    .q_push       (q_push),
    .q_entry      (q_wr_entry)
  );

  // decoupling queue
  mcfd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .wr         (q_push),
    .wr_data    (q_wr_entry),
    .almost_full(q_almost_full),
    .rd         (q_pop),
    .q_empty    (q_empty),
    .rd_data    (q_rd_entry)
  );

  // averaging and output register
  mcfd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_data    (q_rd_entry),
    .empty     (empty),
    .pop       (pop),
    .out_color (out_color),
    .out_x     (out_x),
    .out_y     (out_y),
    .last_pixel(last_pixel)
  );

endmodule

// ===== tb/tb.sv =====
// testbench for the cross filter mipmap downsampler: raster pixels in, averaged
// next-level pixels out, checked against a behavioral model of the filter
// depends on mcfd_pkg and mipmap_cross_filter_downsampler
module tb;
  import mcfd_pkg::*;

  localparam int MAX_DIM      = 2048;
  localparam int RANDOM_ITEMS = 510;
  localparam int CALM_ITEMS   = 150;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE_WAIT  = 8;
  localparam int CYCLE_LIMIT  = 1_000_000;

  // one pixel of the next mipmap level
  typedef struct packed {
    logic [PIX_W-1:0]   color;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               last;
  } down_pix_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   push = 1'b0;
  logic                   full;
  logic [PIX_W-1:0]       pixel_color = '0;
  logic                   empty;
  logic                   pop = 1'b0;
  logic [PIX_W-1:0]       out_color;
  logic [COORD_W-1:0]     out_x;
  logic [COORD_W-1:0]     out_y;
  logic                   last_pixel;

  mipmap_cross_filter_downsampler dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .push(push), .full(full), .pixel_color(pixel_color),
    .empty(empty), .pop(pop),
    .out_color(out_color), .out_x(out_x), .out_y(out_y), .last_pixel(last_pixel)
  );

  // model state: size registers, raster position and the two line stores
  logic [CFG_DATA_W-1:0] src_width = 12'd2;
  logic [CFG_DATA_W-1:0] src_height = 12'd2;
  int                    col_pos = 0;
  int                    row_pos = 0;
  logic [PIX_W-1:0]      center_row [MAX_DIM];
  logic [PIX_W-1:0]      above_row [MAX_DIM];

  logic [PIX_W-1:0] source_queue [$];
  down_pix_t        mip_expected [$];
  int               pixels_loaded = 0;
  int               pixels_accepted = 0;
  int               error_count = 0;
  int               cycle_count = 0;
  int               send_gap = 0;
  int               recv_gap = 0;
  bit               calm = 1'b0;
  bit               hold_go = 1'b0;
  logic             long_hold = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int clamp_dim(input logic [CFG_DATA_W-1:0] v);
    if (v < 2) return 2;
    if (v > MAX_DIM) return MAX_DIM;
    return int'(v);
  endfunction

  task automatic report_error(input string msg);
    $display("ERROR: %s", msg);
    error_count++;
  endtask

  // advance the model by one source pixel, queue the output pixel it completes
  task automatic downsample_pixel(input logic [PIX_W-1:0] px);
    int w, h, j, i, cnt, sum, s, k;
    logic [PIX_W-1:0] nb [5];
    down_pix_t res;
    w = clamp_dim(src_width);
    h = clamp_dim(src_height);
    if (row_pos % 2 == 1 && col_pos % 2 == 0 && col_pos < (w / 2) * 2 &&
        row_pos < (h / 2) * 2) begin
      j = col_pos / 2;
      i = row_pos / 2;
      nb[0] = center_row[col_pos];
      nb[1] = center_row[col_pos + 1];
      nb[2] = px;
      cnt = 3;
      if (j > 0) begin
        nb[cnt] = center_row[col_pos - 1];
        cnt++;
      end
      if (i > 0) begin
        nb[cnt] = above_row[col_pos];
        cnt++;
      end
      // per-channel truncated mean
      for (s = 0; s < PIX_W; s += 8) begin
        sum = 0;
        for (k = 0; k < cnt; k++) sum += int'(nb[k][s +: 8]);
        res.color[s +: 8] = 8'(sum / cnt);
      end
      res.x = COORD_W'(j);
      res.y = COORD_W'(i);
      res.last = (j == w / 2 - 1) && (i == h / 2 - 1);
      mip_expected.push_back(res);
    end
    if (row_pos % 2 == 0) center_row[col_pos] = px;
    else above_row[col_pos] = px;
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) row_pos = 0;
    end
  endtask

  // random pixel with saturated channels mixed in
  function automatic logic [PIX_W-1:0] rand_pixel();
    logic [PIX_W-1:0] px;
    int s;
    for (s = 0; s < PIX_W; s += 8) begin
      case ($urandom_range(0, 3))
        0: px[s +: 8] = 8'h00;
        1: px[s +: 8] = 8'hff;
        default: px[s +: 8] = 8'($urandom);
      endcase
    end
    return px;
  endfunction

  task automatic load_pixel(input logic [PIX_W-1:0] px);
    source_queue.push_back(px);
    pixels_loaded++;
  endtask

  task automatic load_random(input int n);
    int k;
    for (k = 0; k < n; k++) load_pixel(rand_pixel());
  endtask

  // wait for every pixel to transfer and every output to drain
  task automatic settle();
    while (pixels_accepted != pixels_loaded || mip_expected.size() != 0)
      @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  // register write; either register restarts the frame
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_SOURCE_WIDTH) src_width = val;
    else src_height = val;
    col_pos = 0;
    row_pos = 0;
  endtask

  // driver: offers queued pixels, predicts each one on its transfer
  always @(posedge clk) begin : driver
    logic next_push;
    next_push = push;
    if (rst) begin
      next_push = 1'b0;
    end else begin
      if (push && !full) begin
        downsample_pixel(pixel_color);
        pixels_accepted++;
        next_push = 1'b0;
      end
      if (!next_push) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (source_queue.size() > 0) begin
          if (!calm && $urandom_range(0, 9) == 0) begin
            send_gap = $urandom_range(0, 14);
          end else begin
            next_push = 1'b1;
            pixel_color <= source_queue.pop_front();
          end
        end
      end
    end
    push <= next_push;
  end

  // monitor: checks each output transfer against the oldest expectation
  always @(posedge clk) begin : monitor
    down_pix_t want;
    if (!rst && pop && !empty) begin
      if (mip_expected.size() == 0) begin
        report_error($sformatf("unexpected output pixel x=%0d y=%0d color=%h",
                               out_x, out_y, out_color));
      end else begin
        want = mip_expected.pop_front();
        if (out_color !== want.color)
          report_error($sformatf("color at (%0d,%0d): got %h want %h",
                                 want.x, want.y, out_color, want.color));
        if (out_x !== want.x)
          report_error($sformatf("out_x: got %0d want %0d", out_x, want.x));
        if (out_y !== want.y)
          report_error($sformatf("out_y: got %0d want %0d", out_y, want.y));
        if (last_pixel !== want.last)
          report_error($sformatf("last_pixel at (%0d,%0d): got %b want %b",
                                 want.x, want.y, last_pixel, want.last));
      end
    end
    if (recv_gap > 0) begin
      recv_gap--;
      pop <= 1'b0;
    end else if (long_hold) begin
      pop <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      recv_gap = $urandom_range(0, 14);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  // long receiver hold so the block backs up and raises full
  initial begin
    wait (hold_go);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    long_hold <= 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // stimulus sequence
  initial begin
    logic [CFG_DATA_W-1:0] wv, hv;
    int n, sel, random_items;
    random_items = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset size 2x2: black/white, then all white
    load_pixel(32'h00000000);
    load_pixel(32'hffffffff);
    load_pixel(32'h00000000);
    load_pixel(32'hffffffff);
    load_pixel(32'hffffffff);
    load_pixel(32'hffffffff);
    load_pixel(32'hffffffff);
    load_pixel(32'hffffffff);
    settle();

    // 4x4: left and above neighbors join the filter
    write_reg(REG_SOURCE_WIDTH, 12'd4);
    write_reg(REG_SOURCE_HEIGHT, 12'd4);
    load_random(16);
    settle();

    // widest rows: clamped width, partial first row cut off by the next write
    write_reg(REG_SOURCE_WIDTH, 12'hfff);
    write_reg(REG_SOURCE_HEIGHT, 12'd0);
    load_random(64);
    settle();

    // narrow column: width below range, height above range
    write_reg(REG_SOURCE_WIDTH, 12'd1);
    write_reg(REG_SOURCE_HEIGHT, 12'd2049);
    load_random(128);
    settle();

    // receiver holds off while frames keep coming
    write_reg(REG_SOURCE_WIDTH, 12'd8);
    write_reg(REG_SOURCE_HEIGHT, 12'd8);
    hold_go = 1'b1;
    load_random(256);
    settle();

    // odd size; sender pauses mid-frame until every output has drained
    write_reg(REG_SOURCE_WIDTH, 12'd7);
    write_reg(REG_SOURCE_HEIGHT, 12'd5);
    load_random(17);
    settle();
    load_random(18 + 35);
    settle();

    // random sizes, whole frames plus a partial one cut off by the next write
    while (random_items < RANDOM_ITEMS) begin
      if (random_items >= RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
      sel = $urandom_range(0, 2);
      case ($urandom_range(0, 7))
        0: wv = CFG_DATA_W'($urandom_range(0, 1));
        1: wv = CFG_DATA_W'($urandom_range(17, 40));
        default: wv = CFG_DATA_W'($urandom_range(2, 16));
      endcase
      case ($urandom_range(0, 7))
        0: hv = CFG_DATA_W'($urandom_range(0, 1));
        default: hv = CFG_DATA_W'($urandom_range(2, 12));
      endcase
      if (sel != 2) write_reg(REG_SOURCE_WIDTH, wv);
      if (sel != 1) write_reg(REG_SOURCE_HEIGHT, hv);
      n = clamp_dim(src_width) * clamp_dim(src_height);
      n = n * $urandom_range(1, 3) + $urandom_range(0, n - 1);
      // keep the item budget and stop at the start of the calm part
      if (!calm && random_items + n > RANDOM_ITEMS - CALM_ITEMS)
        n = RANDOM_ITEMS - CALM_ITEMS - random_items;
      if (random_items + n > RANDOM_ITEMS) n = RANDOM_ITEMS - random_items;
      load_random(n);
      random_items += n;
      settle();
    end

    if (error_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== files.f =====
src/mcfd_pkg.sv
src/mcfd_front.sv
src/mcfd_queue.sv
src/mcfd_back.sv
src/mipmap_cross_filter_downsampler.sv
tb/tb.sv
